// ===== sv/swcs_pkg.sv =====
// ----------------------------------------------------------------------------
// swcs_pkg
// Shared item types, protocol codes and the header checksum for the
// stop-and-wait connection sender.
// ----------------------------------------------------------------------------
package swcs_pkg;

	// request kinds
	localparam logic [1:0] REQ_HDR  = 2'd0;
	localparam logic [1:0] REQ_SEND = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	// connection phases
	localparam logic [2:0] PH_LISTEN    = 3'd0;
	localparam logic [2:0] PH_HALF_OPEN = 3'd1;
	localparam logic [2:0] PH_ESTAB     = 3'd2;
	localparam logic [2:0] PH_WAIT_ACK  = 3'd3;
	localparam logic [2:0] PH_CLOSING   = 3'd4;
	localparam logic [2:0] PH_CLOSED    = 3'd5;

	// event codes
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_ESTAB    = 3'd1;
	localparam logic [2:0] EV_ACKED    = 3'd2;
	localparam logic [2:0] EV_RETX     = 3'd3;
	localparam logic [2:0] EV_PEER_FIN = 3'd4;
	localparam logic [2:0] EV_CLOSED   = 3'd5;
	localparam logic [2:0] EV_REJECT   = 3'd6;

	// flag bytes
	localparam logic [7:0] FL_SYN     = 8'h01;
	localparam logic [7:0] FL_ACK     = 8'h02;
	localparam logic [7:0] FL_FIN     = 8'h04;
	localparam logic [7:0] FL_SYN_ACK = 8'h03;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [7:0]  flags;
		logic [15:0] check_sum;
		logic [31:0] data_length;
		logic [9:0]  new_seq;
	} req_t;

	typedef struct packed {
		logic        tx_valid;
		logic [31:0] tx_seq;
		logic [31:0] tx_ack;
		logic [7:0]  tx_flags;
		logic [15:0] tx_check_sum;
		logic [31:0] tx_length;
		logic [2:0]  conn_state;
		logic [2:0]  event_res;
		logic        last;
	} res_t;

	// Ones'-complement sum of the seven header halfwords, complemented.
	// A wide sum folded twice gives the same value as a running end-around add.
	function automatic logic [15:0] hdr_sum(input logic [31:0] seq, input logic [31:0] ack,
		input logic [7:0] fl, input logic [31:0] len);
		logic [18:0] t;
		logic [16:0] f;
		logic [15:0] s;
		t = {3'd0, seq[31:16]} + {3'd0, seq[15:0]} + {3'd0, ack[31:16]}
			+ {3'd0, ack[15:0]} + {11'd0, fl} + {3'd0, len[31:16]} + {3'd0, len[15:0]};
		f = {1'b0, t[15:0]} + {14'd0, t[18:16]};
		s = f[15:0] + {15'd0, f[16]};
		return ~s;
	endfunction

endpackage

// ===== sv/stop_and_wait_connection_sender.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_connection_sender
// Passive-side connection engine with stop-and-wait header sending.
// ----------------------------------------------------------------------------
// Takes one request item per clock while no stall holds it off: a received
// header, a send request or a timeout tick. An item is registered on entry,
// resolved into its result item(s) when it fires, and the first result is
// then registered in the result register. Sustained rate is one item per cycle
// while res_stall is low; a FIN received while established yields two results
// (ACK then FIN): the FIN waits in the spare slot and holds off the next item
// until it moves into the result register. Result-side stall backs up into the
// request channel through the entry register.
module stop_and_wait_connection_sender import swcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic valid_s1;
	req_t item_s1;
	logic fire;
	logic busy;
	res_t r0;
	res_t r1;
	logic two;

	assign fire      = valid_s1 && !busy;
	assign req_stall = valid_s1 && !fire;

	// entry register: take a new item when empty or when the held one resolves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || fire) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || fire) && req_valid) begin
			item_s1 <= req;
		end
	end

	swcs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.r0     (r0),
		.r1     (r1),
		.two    (two)
	);

	swcs_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.r0        (r0),
		.r1        (r1),
		.two       (two),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res),
		.busy      (busy)
	);

endmodule

// ===== sv/swcs_engine.sv =====
// ----------------------------------------------------------------------------
// swcs_engine
// Connection state and the single-pass decision for one request item:
// produces the first result, an optional second result, and the next state.
// ----------------------------------------------------------------------------
module swcs_engine import swcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t item,
	output res_t r0,
	output res_t r1,
	output logic two
);

	logic [2:0]  phase_q;
	logic [9:0]  own_seq_q;
	logic [31:0] pend_seq_q;
	logic [7:0]  pend_flags_q;
	logic [31:0] pend_len_q;

	logic        good;
	logic        tx;
	logic [31:0] t_seq;
	logic [31:0] t_ack;
	logic [7:0]  t_fl;
	logic [31:0] t_len;
	logic [2:0]  ev;
	logic [2:0]  nphase;
	logic        ld_own;
	logic        ld_pend;
	logic [31:0] seq_inc;

	assign good    = hdr_sum(item.seq_num, item.ack_num, item.flags, item.data_length)
		== item.check_sum;
	assign seq_inc = item.seq_num + 32'd1;

	// decide on the item
	always_comb begin
		tx      = 1'b0;
		t_seq   = '0;
		t_ack   = '0;
		t_fl    = '0;
		t_len   = '0;
		ev      = EV_NONE;
		nphase  = phase_q;
		ld_own  = 1'b0;
		ld_pend = 1'b0;
		two     = 1'b0;
		case (item.req_type)
			REQ_SEND: begin
				if (phase_q == PH_ESTAB) begin
					ld_pend = 1'b1;
					nphase  = PH_WAIT_ACK;
					tx      = 1'b1;
					t_seq   = item.seq_num;
					t_fl    = item.flags;
					t_len   = item.data_length;
				end else begin
					ev = EV_REJECT;
				end
			end
			REQ_TICK: begin
				if (phase_q == PH_WAIT_ACK) begin
					tx    = 1'b1;
					t_seq = pend_seq_q;
					t_fl  = pend_flags_q;
					t_len = pend_len_q;
					ev    = EV_RETX;
				end
			end
			REQ_HDR: begin
				ev = EV_REJECT;
				unique case (phase_q)
					PH_LISTEN: begin
						if (item.flags == FL_SYN && good) begin
							ld_own = 1'b1;
							nphase = PH_HALF_OPEN;
							tx     = 1'b1;
							t_seq  = {22'd0, item.new_seq};
							t_ack  = seq_inc;
							t_fl   = FL_SYN_ACK;
							ev     = EV_NONE;
						end
					end
					PH_HALF_OPEN: begin
						if (item.flags == FL_ACK && good
							&& item.ack_num == ({22'd0, own_seq_q} + 32'd1)) begin
							nphase = PH_ESTAB;
							ev     = EV_ESTAB;
						end
					end
					PH_ESTAB: begin
						if (item.flags == FL_FIN && good) begin
							ld_own = 1'b1;
							nphase = PH_CLOSING;
							tx     = 1'b1;
							t_ack  = seq_inc;
							t_fl   = FL_ACK;
							ev     = EV_PEER_FIN;
							two    = 1'b1;
						end
					end
					PH_WAIT_ACK: begin
						if (item.flags == FL_FIN) begin
							ld_own = 1'b1;
							nphase = PH_CLOSING;
							tx     = 1'b1;
							t_seq  = {22'd0, item.new_seq};
							t_fl   = FL_FIN;
							ev     = EV_PEER_FIN;
						end else if (item.flags == FL_ACK && good
							&& item.ack_num == (pend_seq_q + 32'd1)) begin
							nphase = PH_ESTAB;
							ev     = EV_ACKED;
						end else begin
							tx    = 1'b1;
							t_seq = pend_seq_q;
							t_fl  = pend_flags_q;
							t_len = pend_len_q;
							ev    = EV_RETX;
						end
					end
					PH_CLOSING: begin
						if (item.flags == FL_ACK && good) begin
							nphase = PH_CLOSED;
							ev     = EV_CLOSED;
						end
					end
					default: begin
						ev = EV_REJECT;
					end
				endcase
			end
			default: begin
				ev = EV_NONE;
			end
		endcase
	end

	// assemble the results
	always_comb begin
		r0.tx_valid     = tx;
		r0.tx_seq       = t_seq;
		r0.tx_ack       = t_ack;
		r0.tx_flags     = t_fl;
		r0.tx_check_sum = tx ? hdr_sum(t_seq, t_ack, t_fl, t_len) : 16'd0;
		r0.tx_length    = t_len;
		r0.conn_state   = nphase;
		r0.event_res    = ev;
		r0.last         = !two;

		r1.tx_valid     = 1'b1;
		r1.tx_seq       = {22'd0, item.new_seq};
		r1.tx_ack       = '0;
		r1.tx_flags     = FL_FIN;
		r1.tx_check_sum = hdr_sum({22'd0, item.new_seq}, 32'd0, FL_FIN, 32'd0);
		r1.tx_length    = '0;
		r1.conn_state   = PH_CLOSING;
		r1.event_res    = EV_PEER_FIN;
		r1.last         = 1'b1;
	end

	// advance the connection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LISTEN;
			own_seq_q    <= '0;
			pend_seq_q   <= '0;
			pend_flags_q <= '0;
			pend_len_q   <= '0;
		end else if (fire) begin
			phase_q <= nphase;
			if (ld_own) begin
				own_seq_q <= item.new_seq;
			end
			if (ld_pend) begin
				pend_seq_q   <= item.seq_num;
				pend_flags_q <= item.flags;
				pend_len_q   <= item.data_length;
			end
		end
	end

endmodule

// ===== sv/swcs_result_buf.sv =====
// ----------------------------------------------------------------------------
// swcs_result_buf
// Result register with one spare slot for the second result of a peer FIN.
// ----------------------------------------------------------------------------
module swcs_result_buf import swcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  res_t r0,
	input  res_t r1,
	input  logic two,
	input  logic res_stall,
	output logic res_valid,
	output res_t res,
	output logic busy
);

	logic res_valid_q;
	res_t res_q;
	logic spare_valid_q;
	res_t spare_q;
	logic open;

	assign open      = !res_valid_q || !res_stall;
	assign busy      = spare_valid_q || !open;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// load the result register, draining the spare slot first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (open) begin
			if (spare_valid_q) begin
				res_valid_q   <= 1'b1;
				spare_valid_q <= 1'b0;
			end else begin
				res_valid_q   <= fire;
				spare_valid_q <= fire && two;
			end
		end
	end

	// hold payload until taken
	always_ff @(posedge clk) begin
		if (open) begin
			if (spare_valid_q) begin
				res_q <= spare_q;
			end else if (fire) begin
				res_q   <= r0;
				spare_q <= r1;
			end
		end
	end

endmodule

// ===== test/swcs_conn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcs_conn_checker
// Watches the request and result channels of the connection sender, keeps a
// shadow of the connection phase and the held segment, predicts the reply
// items of every accepted request and compares them in order with the
// accepted result items.
// ----------------------------------------------------------------------------
module swcs_conn_checker import swcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   fail_count,
	output int   outstanding
);

	// predicted replies, oldest first
	res_t        reply_q[$];
	res_t        want;

	// shadow connection state
	logic [2:0]  cur_phase;
	logic [31:0] isn;
	logic [31:0] held_seq;
	logic [7:0]  held_flags;
	logic [31:0] held_len;

	// Complemented ones'-complement sum of the seven header halfwords, end-around carry
	function automatic logic [15:0] ones_sum16(input logic [31:0] seq, input logic [31:0] ack,
		input logic [7:0] fl, input logic [31:0] len);
		logic [6:0][15:0] words;
		logic [31:0]      acc;
		words = {seq[31:16], seq[15:0], ack[31:16], ack[15:0], {8'd0, fl}, len[31:16],
			len[15:0]};
		acc = 32'd0;
		for (int i = 0; i < 7; i++) begin
			acc = acc + {16'd0, words[i]};
			if (acc[31:16] != 16'd0) begin
				acc = {16'd0, acc[15:0]} + 32'd1;
			end
		end
		return ~acc[15:0];
	endfunction

	function automatic string show_reply(input res_t r);
		return $sformatf("tx=%0b seq=%h ack=%h fl=%h sum=%h len=%h st=%0d ev=%0d last=%0b",
			r.tx_valid, r.tx_seq, r.tx_ack, r.tx_flags, r.tx_check_sum, r.tx_length,
			r.conn_state, r.event_res, r.last);
	endfunction

	// Queue one reply; header fields stay zero when nothing is transmitted
	task automatic push_reply(input logic tx, input logic [31:0] s, input logic [31:0] a,
		input logic [7:0] f, input logic [31:0] l, input logic [2:0] ev, input logic lst);
		res_t r;
		r.tx_valid     = tx;
		r.tx_seq       = tx ? s : 32'd0;
		r.tx_ack       = tx ? a : 32'd0;
		r.tx_flags     = tx ? f : 8'd0;
		r.tx_check_sum = tx ? ones_sum16(s, a, f, l) : 16'd0;
		r.tx_length    = tx ? l : 32'd0;
		r.conn_state   = cur_phase;
		r.event_res    = ev;
		r.last         = lst;
		reply_q.push_back(r);
	endtask

	task automatic push_retransmit();
		push_reply(1'b1, held_seq, 32'd0, held_flags, held_len, EV_RETX, 1'b1);
	endtask

	// Advance the shadow connection by one request item
	task automatic advance_connection(input req_t r);
		logic good;
		logic taken;
		good  = ones_sum16(r.seq_num, r.ack_num, r.flags, r.data_length) == r.check_sum;
		taken = 1'b1;
		case (r.req_type)
		REQ_SEND: begin
			if (cur_phase != PH_ESTAB) begin
				push_reply(1'b0, 32'd0, 32'd0, 8'd0, 32'd0, EV_REJECT, 1'b1);
			end else begin
				held_seq   = r.seq_num;
				held_flags = r.flags;
				held_len   = r.data_length;
				cur_phase  = PH_WAIT_ACK;
				push_reply(1'b1, r.seq_num, 32'd0, r.flags, r.data_length, EV_NONE, 1'b1);
			end
		end
		REQ_TICK: begin
			if (cur_phase == PH_WAIT_ACK) begin
				push_retransmit();
			end else begin
				push_reply(1'b0, 32'd0, 32'd0, 8'd0, 32'd0, EV_NONE, 1'b1);
			end
		end
		REQ_HDR: begin
			taken = 1'b0;
			case (cur_phase)
			PH_LISTEN: begin
				if (r.flags == FL_SYN && good) begin
					isn       = {22'd0, r.new_seq};
					cur_phase = PH_HALF_OPEN;
					push_reply(1'b1, isn, r.seq_num + 32'd1, FL_SYN_ACK, 32'd0, EV_NONE, 1'b1);
					taken = 1'b1;
				end
			end
			PH_HALF_OPEN: begin
				if (r.flags == FL_ACK && r.ack_num == isn + 32'd1 && good) begin
					cur_phase = PH_ESTAB;
					push_reply(1'b0, 32'd0, 32'd0, 8'd0, 32'd0, EV_ESTAB, 1'b1);
					taken = 1'b1;
				end
			end
			PH_ESTAB: begin
				// peer FIN: acknowledge it, then send our own FIN
				if (r.flags == FL_FIN && good) begin
					isn       = {22'd0, r.new_seq};
					cur_phase = PH_CLOSING;
					push_reply(1'b1, 32'd0, r.seq_num + 32'd1, FL_ACK, 32'd0, EV_PEER_FIN, 1'b0);
					push_reply(1'b1, isn, 32'd0, FL_FIN, 32'd0, EV_PEER_FIN, 1'b1);
					taken = 1'b1;
				end
			end
			PH_WAIT_ACK: begin
				taken = 1'b1;
				if (r.flags == FL_FIN) begin
					isn       = {22'd0, r.new_seq};
					cur_phase = PH_CLOSING;
					push_reply(1'b1, isn, 32'd0, FL_FIN, 32'd0, EV_PEER_FIN, 1'b1);
				end else if (r.flags == FL_ACK && r.ack_num == held_seq + 32'd1 && good) begin
					cur_phase = PH_ESTAB;
					push_reply(1'b0, 32'd0, 32'd0, 8'd0, 32'd0, EV_ACKED, 1'b1);
				end else begin
					push_retransmit();
				end
			end
			PH_CLOSING: begin
				if (r.flags == FL_ACK && good) begin
					cur_phase = PH_CLOSED;
					push_reply(1'b0, 32'd0, 32'd0, 8'd0, 32'd0, EV_CLOSED, 1'b1);
					taken = 1'b1;
				end
			end
			default: begin
			end
			endcase
			if (!taken) begin
				push_reply(1'b0, 32'd0, 32'd0, 8'd0, 32'd0, EV_REJECT, 1'b1);
			end
		end
		default: begin
			push_reply(1'b0, 32'd0, 32'd0, 8'd0, 32'd0, EV_NONE, 1'b1);
		end
		endcase
	endtask

	// Compare accepted results, then predict from accepted requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_q.delete();
			cur_phase   = PH_LISTEN;
			isn         = 32'd0;
			held_seq    = 32'd0;
			held_flags  = 8'd0;
			held_len    = 32'd0;
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (reply_q.size() == 0) begin
					if (fail_count < 10) begin
						$display("unexpected result item: %s", show_reply(res));
					end
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (res !== want) begin
						if (fail_count < 10) begin
							$display("result mismatch at %0t", $realtime);
							$display("  expected %s", show_reply(want));
							$display("  actual   %s", show_reply(res));
						end
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				advance_connection(req);
			end
			outstanding = reply_q.size();
		end
	end

endmodule

// ===== test/tb_stop_and_wait_connection_sender.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stop_and_wait_connection_sender
// Drives the connection sender through listen, handshake, a long run of
// stop-and-wait segment exchanges with timeouts and bad packets, and a
// teardown into closed, with random idling on both channels. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_connection_sender;
	import swcs_pkg::*;

	localparam int         CYCLE_LIMIT  = 250000;
	localparam int         RANDOM_ITEMS = 650;
	localparam int         HOLD_OFF     = 80;
	localparam logic [1:0] REQ_SPARE    = 2'd3;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	int   fail_count;
	int   outstanding;
	logic req_taken;
	logic res_taken;

	// idle_on and hold_cycles are shared between the sender and the receiver
	bit   idle_on     = 1'b1;
	int   hold_cycles = 0;
	int   sent        = 0;

	stop_and_wait_connection_sender i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	swcs_conn_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Record handshakes at the rising edge for the drivers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
			res_taken <= 1'b0;
		end else begin
			req_taken <= req_valid && !req_stall;
			res_taken <= res_valid && !res_stall;
		end
	end

	// Header with a good or a deliberately broken checksum
	function automatic req_t make_hdr(input logic [31:0] seq, input logic [31:0] ack,
		input logic [7:0] fl, input logic [31:0] len, input logic good);
		req_t r;
		r.req_type    = REQ_HDR;
		r.seq_num     = seq;
		r.ack_num     = ack;
		r.flags       = fl;
		r.data_length = len;
		r.new_seq     = 10'($urandom);
		r.check_sum   = hdr_sum(seq, ack, fl, len);
		if (!good) begin
			r.check_sum = r.check_sum ^ 16'($urandom_range(1, 65535));
		end
		return r;
	endfunction

	// Random item of one kind; a bare FIN header is bent so the link stays up
	function automatic req_t make_noise(input logic [1:0] kind);
		req_t r;
		r.req_type    = kind;
		r.seq_num     = $urandom;
		r.ack_num     = $urandom;
		r.flags       = 8'($urandom);
		r.check_sum   = 16'($urandom);
		r.data_length = $urandom;
		r.new_seq     = 10'($urandom);
		if (kind == REQ_HDR && r.flags == FL_FIN) begin
			r.flags = r.flags ^ 8'h80;
		end
		return r;
	endfunction

	// Offer one item, after a random gap unless idling is off or a hold-off is set, and hold it until taken
	task automatic send_item(input req_t it);
		int gap;
		gap = (idle_on && hold_cycles == 0) ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(negedge clk);
		while (!req_taken) @(negedge clk);
		sent++;
	endtask

	// Stop offering until every predicted reply has arrived
	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	// Receiver: random stall per result item while idling is on, one long hold-off on request
	initial begin : receiver
		int w;
		forever begin
			if (hold_cycles > 0) begin
				res_stall <= 1'b1;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			w = idle_on ? $urandom_range(0, 9) : 0;
			if (w > 0) begin
				res_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			res_stall <= 1'b0;
			@(negedge clk);
			while (!res_taken) @(negedge clk);
		end
	end

	// Bound the run
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_stop_and_wait_connection_sender NOT OK");
		$finish;
	end

	initial begin : stimulus
		req_t h;
		req_t seg;
		int   variant;
		int   base;
		bit   held;
		bit   paused;
		held   = 1'b0;
		paused = 1'b0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// listen: everything but a clean SYN is turned away
		send_item(make_noise(REQ_TICK));
		h          = '1;
		h.req_type = REQ_SPARE;
		send_item(h);
		send_item(make_noise(REQ_SEND));
		send_item(make_hdr($urandom, $urandom, FL_SYN, $urandom, 1'b0));
		send_item(make_hdr($urandom, $urandom, FL_SYN_ACK, $urandom, 1'b1));
		send_item(make_hdr($urandom, $urandom, FL_SYN | 8'h80, $urandom, 1'b1));
		// SYN at the top of the sequence space, largest initial number
		h         = make_hdr(32'hFFFF_FFFF, 32'hFFFF_FFFF, FL_SYN, 32'hFFFF_FFFF, 1'b1);
		h.new_seq = 10'h3FF;
		send_item(h);

		// half open: only the right ACK with a good checksum opens the link
		send_item(make_hdr($urandom, $urandom, FL_SYN, $urandom, 1'b1));
		send_item(make_hdr($urandom, 32'd1024, FL_ACK, $urandom, 1'b0));
		send_item(make_hdr($urandom, 32'd1023, FL_ACK, $urandom, 1'b1));
		send_item(make_hdr(32'd0, 32'd1024, FL_ACK, 32'd0, 1'b1));

		// established and wait_ack corner cases
		send_item(make_noise(REQ_TICK));
		send_item(make_hdr($urandom, $urandom, FL_FIN, $urandom, 1'b0));
		send_item(make_hdr($urandom, $urandom, FL_ACK, $urandom, 1'b1));
		h          = '1;
		h.req_type = REQ_SEND;
		send_item(h);
		send_item(make_noise(REQ_TICK));
		send_item(make_noise(REQ_SEND));
		send_item(make_hdr($urandom, 32'd0, FL_ACK, $urandom, 1'b0));
		send_item(make_hdr($urandom, 32'hFFFF_FFFF, FL_ACK, $urandom, 1'b1));
		send_item(make_hdr($urandom, $urandom, 8'h00, $urandom, 1'b1));
		send_item(make_noise(REQ_SPARE));
		send_item(make_hdr($urandom, 32'd0, FL_ACK, $urandom, 1'b1));
		h          = '0;
		h.req_type = REQ_SEND;
		send_item(h);
		send_item(make_hdr($urandom, 32'd1, FL_ACK, $urandom, 1'b1));
		drain();

		// random segment exchanges: send, disturbances, clean ACK, idle noise
		base = sent;
		while (sent < base + RANDOM_ITEMS) begin
			seg = make_noise(REQ_SEND);
			send_item(seg);
			repeat ($urandom_range(0, 3)) begin
				case ($urandom_range(0, 5))
				0: send_item(make_noise(REQ_TICK));
				1: send_item(make_noise(REQ_HDR));
				2: send_item(make_hdr($urandom, seg.seq_num + 32'd1, FL_ACK, $urandom, 1'b0));
				3: send_item(make_hdr($urandom, seg.seq_num + 32'($urandom_range(2, 9)),
					FL_ACK, $urandom, 1'b1));
				4: send_item(make_noise(REQ_SEND));
				default: send_item(make_noise(REQ_SPARE));
				endcase
			end
			send_item(make_hdr($urandom, seg.seq_num + 32'd1, FL_ACK, $urandom, 1'b1));
			repeat ($urandom_range(0, 2)) begin
				case ($urandom_range(0, 2))
				0: send_item(make_noise(REQ_TICK));
				1: send_item(make_noise(REQ_SPARE));
				default: send_item(make_noise(REQ_HDR));
				endcase
			end

			// long receiver hold-off while items keep coming, then a full drain
			if (!held && sent > base + 200) begin
				hold_cycles = HOLD_OFF;
				held        = 1'b1;
			end
			if (!paused && sent > base + 400) begin
				drain();
				paused = 1'b1;
			end
			idle_on = ((sent / 64) % 4) != 3;
		end

		// teardown: FIN from established (two replies) or FIN while waiting
		idle_on = 1'b1;
		variant = $urandom_range(0, 2);
		if (variant == 0) begin
			send_item(make_noise(REQ_SEND));
			send_item(make_hdr($urandom, $urandom, FL_FIN, $urandom, 1'b0));
		end else begin
			h         = make_hdr(32'hFFFF_FFFF, $urandom, FL_FIN, $urandom, 1'b1);
			h.new_seq = 10'h000;
			send_item(h);
		end

		// closing: only a clean ACK closes
		send_item(make_hdr($urandom, $urandom, FL_FIN, $urandom, 1'b1));
		send_item(make_hdr($urandom, $urandom, FL_ACK, $urandom, 1'b0));
		send_item(make_noise(REQ_TICK));
		send_item(make_noise(REQ_SEND));
		send_item(make_hdr($urandom, $urandom, FL_ACK, $urandom, 1'b1));

		// closed: nothing gets through any more
		send_item(make_hdr($urandom, $urandom, FL_SYN, $urandom, 1'b1));
		send_item(make_hdr($urandom, $urandom, FL_ACK, $urandom, 1'b1));
		repeat (12) send_item(make_noise(2'($urandom)));

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("tb_stop_and_wait_connection_sender OK");
		end else begin
			$display("tb_stop_and_wait_connection_sender NOT OK");
		end
		$finish;
	end

endmodule

// ===== stop_and_wait_connection_sender.f =====
sv/swcs_pkg.sv
sv/swcs_engine.sv
sv/swcs_result_buf.sv
sv/stop_and_wait_connection_sender.sv
test/swcs_conn_checker.sv
test/tb_stop_and_wait_connection_sender.sv
